@@ hdl/ddq_pkg.sv @@
// ----------------------------------------------------------------------------
// ddq_pkg
// Shared types and codes for the double-ended queue core.
// ----------------------------------------------------------------------------
package ddq_pkg;

   localparam int WORD_W = 32;

   localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_QUERY      = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic [2:0]               opcode;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] back_value;
      logic [4:0]               entry_count;
      logic [1:0]               status;
   } rsp_type;

   // chain operation for one cycle; head is cell 0
   typedef struct packed {
      logic ins_head;
      logic del_head;
      logic ins_tail;
      logic del_tail;
   } ctl_type;

endpackage

@@ hdl/double_ended_queue_core.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_core
// A result word is registered and shown in the cycle after its request is taken.
// Throughput: one request per cycle while the result is not stalled; each operation
// is one shift or fill step across both cell rows, which move in the same cycle.
// Reset: synchronous; the deque comes up empty with no result pending.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ddq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ddq_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   ddq_pkg::ctl_type ctl_f, ctl_b;
   logic signed [ddq_pkg::WORD_W-1:0] f_head, b_head;
   logic f_vld, b_vld, f_full, b_full;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      ctl_f     = '0;
      ctl_b     = '0;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      if (accept) begin
         status_in = ddq_pkg::ST_OK;
         case (req_data.opcode)
            ddq_pkg::OP_PUSH_BACK: begin
               if (f_full) begin
                  status_in = ddq_pkg::ST_OVERFLOW;
               end else begin
                  ctl_f.ins_tail = 1'b1;
                  ctl_b.ins_head = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            ddq_pkg::OP_PUSH_FRONT: begin
               if (f_full) begin
                  status_in = ddq_pkg::ST_OVERFLOW;
               end else begin
                  ctl_f.ins_head = 1'b1;
                  ctl_b.ins_tail = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            ddq_pkg::OP_POP_FRONT: begin
               if (!f_vld) begin
                  status_in = ddq_pkg::ST_UNDERFLOW;
               end else begin
                  ctl_f.del_head = 1'b1;
                  ctl_b.del_tail = 1'b1;
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
            ddq_pkg::OP_POP_BACK: begin
               if (!f_vld) begin
                  status_in = ddq_pkg::ST_UNDERFLOW;
               end else begin
                  ctl_f.del_tail = 1'b1;
                  ctl_b.del_head = 1'b1;
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
            default: begin
               status_in = ddq_pkg::ST_OK;
            end
         endcase
      end
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // front-ordered row
   ddq_chain #(.DEPTH(CAPACITY)) u_front_row (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_f),
      .push_val (req_data.push_value),
      .head_val (f_head),
      .head_vld (f_vld),
      .full     (f_full)
   );

   // back-ordered row
   ddq_chain #(.DEPTH(CAPACITY)) u_back_row (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_b),
      .push_val (req_data.push_value),
      .head_val (b_head),
      .head_vld (b_vld),
      .full     (b_full)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.front_value = f_vld ? f_head : '0;
   assign rsp_data.back_value  = (b_vld && !(b_full && !f_full)) ? b_head : '0;
   assign rsp_data.entry_count = 5'(cnt_ff);
   assign rsp_data.status      = status_ff;

endmodule

@@ hdl/ddq_cell.sv @@
// ----------------------------------------------------------------------------
// ddq_cell
// One storage cell of the chain: holds a word and its valid bit, and moves
// toward or away from the head, or fills or drops at the tail.
// ----------------------------------------------------------------------------
module ddq_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  ddq_pkg::ctl_type                ctl,
   input  logic signed [ddq_pkg::WORD_W-1:0] push_val,
   input  logic signed [ddq_pkg::WORD_W-1:0] prev_val,
   input  logic                            prev_vld,
   input  logic signed [ddq_pkg::WORD_W-1:0] next_val,
   input  logic                            next_vld,
   output logic signed [ddq_pkg::WORD_W-1:0] val,
   output logic                            vld
);

   logic signed [ddq_pkg::WORD_W-1:0] val_ff, val_in;
   logic                              vld_ff, vld_in;

   always_comb begin
      val_in = val_ff;
      vld_in = vld_ff;
      if (ctl.ins_head) begin
         val_in = prev_val;
         vld_in = prev_vld;
      end else if (ctl.del_head) begin
         val_in = next_val;
         vld_in = next_vld;
      end else if (ctl.ins_tail) begin
         if (prev_vld && !vld_ff) begin
            val_in = push_val;
            vld_in = 1'b1;
         end
      end else if (ctl.del_tail) begin
         if (vld_ff && !next_vld) begin
            vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign val = val_ff;
   assign vld = vld_ff;

endmodule

@@ hdl/ddq_chain.sv @@
// ----------------------------------------------------------------------------
// ddq_chain
// Row of cells with the head at cell 0; shows the head word and whether the
// row is full.
// ----------------------------------------------------------------------------
module ddq_chain #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ddq_pkg::ctl_type                  ctl,
   input  logic signed [ddq_pkg::WORD_W-1:0] push_val,
   output logic signed [ddq_pkg::WORD_W-1:0] head_val,
   output logic                              head_vld,
   output logic                              full
);

   logic signed [ddq_pkg::WORD_W-1:0] cell_val [DEPTH];
   logic                              cell_vld [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [ddq_pkg::WORD_W-1:0] p_val, n_val;
      logic                              p_vld, n_vld;

      if (i == 0) begin : g_first
         assign p_val = push_val;
         assign p_vld = 1'b1;
      end else begin : g_mid
         assign p_val = cell_val[i-1];
         assign p_vld = cell_vld[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign n_val = '0;
         assign n_vld = 1'b0;
      end else begin : g_inner
         assign n_val = cell_val[i+1];
         assign n_vld = cell_vld[i+1];
      end

      ddq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .push_val (push_val),
         .prev_val (p_val),
         .prev_vld (p_vld),
         .next_val (n_val),
         .next_vld (n_vld),
         .val      (cell_val[i]),
         .vld      (cell_vld[i])
      );
   end

   assign head_val = cell_val[0];
   assign head_vld = cell_vld[0];
   assign full     = cell_vld[DEPTH-1];

endmodule

@@ hdl/ddq_checker.sv @@
// ----------------------------------------------------------------------------
// ddq_checker
// Port-level checks of the double-ended queue core, bound to the top level.
// ----------------------------------------------------------------------------
module ddq_checker #(
   parameter int CAPACITY = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input ddq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ddq_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted word gave no result");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ddq_pkg::ST_UNDERFLOW
      |-> rsp_data.entry_count == 5'd0 && rsp_data.front_value == '0
          && rsp_data.back_value == '0)
      else $error("underflow reported on a non-empty deque");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ddq_pkg::ST_OVERFLOW
      |-> rsp_data.entry_count == 5'(CAPACITY))
      else $error("overflow reported on a deque that is not full");

   a_push_back_seen: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.opcode == ddq_pkg::OP_PUSH_BACK
      |=> rsp_data.status == ddq_pkg::ST_OVERFLOW
          || rsp_data.back_value == $past(req_data.push_value))
      else $error("pushed word not at back");

endmodule

bind double_ended_queue_core ddq_checker #(.CAPACITY(CAPACITY)) u_ddq_checker (.*);

@@ tb/double_ended_queue_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_core_tb
// Drives push, pop, query and reserved-opcode words into the deque core, under random
// back pressure in two of its three phases, and checks every result word against a
// ring-buffer predictor.
module double_ended_queue_core_tb;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;

   localparam logic [2:0] OP_RSVD_5 = 3'd5;
   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ddq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ddq_pkg::rsp_type rsp_data;

   ddq_pkg::req_type pending_reqs [$];
   ddq_pkg::rsp_type expected_rsps [$];

   logic signed [ddq_pkg::WORD_W-1:0] ring_words [DEPTH];
   int      head_idx;
   int      fill_cnt;

   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      cycle_count    = 0;
   int      error_count    = 0;
   int      sent_count     = 0;
   int      checked_count  = 0;
   int      full_hits      = 0;
   int      underflow_hits = 0;
   int      overflow_hits  = 0;

   ddq_pkg::req_type drv_next;
   logic             drv_go;
   ddq_pkg::rsp_type mon_want;

   double_ended_queue_core #(
      .CAPACITY (DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic ddq_pkg::rsp_type deque_apply(ddq_pkg::req_type r);
      ddq_pkg::rsp_type o;
      o = '0;
      o.status = ddq_pkg::ST_OK;
      case (r.opcode)
         ddq_pkg::OP_PUSH_BACK, ddq_pkg::OP_PUSH_FRONT: begin
            if (fill_cnt >= DEPTH) begin
               o.status = ddq_pkg::ST_OVERFLOW;
               overflow_hits++;
            end else begin
               if (r.opcode == ddq_pkg::OP_PUSH_BACK) begin
                  ring_words[(head_idx + fill_cnt) % DEPTH] = r.push_value;
               end else begin
                  head_idx = (head_idx + DEPTH - 1) % DEPTH;
                  ring_words[head_idx] = r.push_value;
               end
               fill_cnt++;
               if (fill_cnt == DEPTH) full_hits++;
            end
         end
         ddq_pkg::OP_POP_FRONT, ddq_pkg::OP_POP_BACK: begin
            if (fill_cnt == 0) begin
               o.status = ddq_pkg::ST_UNDERFLOW;
               underflow_hits++;
            end else begin
               if (r.opcode == ddq_pkg::OP_POP_FRONT) head_idx = (head_idx + 1) % DEPTH;
               fill_cnt--;
            end
         end
         default: ;
      endcase
      if (fill_cnt != 0) begin
         o.front_value = ring_words[head_idx];
         o.back_value  = ring_words[(head_idx + fill_cnt - 1) % DEPTH];
      end
      o.entry_count = fill_cnt[4:0];
      return o;
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic add_word(input logic [2:0] op, input logic [ddq_pkg::WORD_W-1:0] val);
      ddq_pkg::req_type r;
      r.opcode     = op;
      r.push_value = val;
      pending_reqs.push_back(r);
   endtask

   function automatic logic [ddq_pkg::WORD_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_random(input int n);
      int         mode;
      int         push_pct;
      logic [2:0] op;
      mode = MODE_FILL;
      for (int i = 0; i < n; i++) begin
         if (i % 32 == 0) mode = $urandom_range(0, 2);
         push_pct = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 25 : 50;
         if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 3))
               0:       op = ddq_pkg::OP_QUERY;
               1:       op = OP_RSVD_5;
               2:       op = OP_RSVD_6;
               default: op = OP_RSVD_7;
            endcase
         end else if ($urandom_range(0, 99) < push_pct) begin
            op = $urandom_range(0, 1) ? ddq_pkg::OP_PUSH_FRONT : ddq_pkg::OP_PUSH_BACK;
         end else begin
            op = $urandom_range(0, 1) ? ddq_pkg::OP_POP_FRONT : ddq_pkg::OP_POP_BACK;
         end
         add_word(op, pick_value());
      end
   endtask

   // advance the predictor on each accepted word, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_rsps.push_back(deque_apply(req_data));
            sent_count++;
         end
         drv_go = (pending_reqs.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
         if (drv_go) begin
            drv_next = pending_reqs.pop_front();
            req_data <= drv_next;
         end
         req_valid <= drv_go;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               flag_error("result word with nothing expected");
            end else begin
               mon_want = expected_rsps.pop_front();
               checked_count++;
               if (rsp_data.front_value !== mon_want.front_value ||
                   rsp_data.back_value  !== mon_want.back_value  ||
                   rsp_data.entry_count !== mon_want.entry_count ||
                   rsp_data.status      !== mon_want.status) begin
                  flag_error($sformatf(
                     "word %0d exp f=%h b=%h n=%0d s=%0d got f=%h b=%h n=%0d s=%0d",
                     checked_count, mon_want.front_value, mon_want.back_value,
                     mon_want.entry_count, mon_want.status, rsp_data.front_value,
                     rsp_data.back_value, rsp_data.entry_count, rsp_data.status));
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("double_ended_queue_core_tb failed");
         $finish;
      end
   end

   initial begin
      head_idx = 0;
      fill_cnt = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 11;
      recv_stall_pct = 45;

      add_word(ddq_pkg::OP_QUERY,      32'h1234_5678);
      add_word(ddq_pkg::OP_POP_FRONT,  32'h0000_0000);
      add_word(ddq_pkg::OP_POP_BACK,   32'hFFFF_FFFF);
      add_word(ddq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF);
      add_word(ddq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
      add_word(OP_RSVD_5,              32'hDEAD_BEEF);
      add_word(ddq_pkg::OP_POP_BACK,   32'h0000_0000);
      add_word(ddq_pkg::OP_POP_FRONT,  32'h0000_0000);
      add_word(OP_RSVD_6,              32'hFFFF_FFFF);
      add_word(ddq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
      add_word(ddq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF);
      add_word(ddq_pkg::OP_PUSH_FRONT, 32'h5555_5555);
      add_word(ddq_pkg::OP_PUSH_BACK,  32'hAAAA_AAAA);
      for (int i = 0; i < 12; i++) begin
         add_word((i % 2) ? ddq_pkg::OP_PUSH_BACK : ddq_pkg::OP_PUSH_FRONT, $urandom);
      end
      add_word(ddq_pkg::OP_PUSH_BACK,  32'h0BAD_0BAD);
      add_word(ddq_pkg::OP_PUSH_FRONT, 32'h0BAD_0BAD);
      add_word(OP_RSVD_7,              32'h8000_0000);
      add_random(290);

      // hold until every expected word is back
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);

      send_idle_pct  = 45;
      recv_stall_pct = 11;
      add_random(290);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      add_random(270);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d request words sent, %0d result words checked, %0d mismatches",
               sent_count, checked_count, error_count);
      $display("deque full %0d times, %0d underflows, %0d overflows",
               full_hits, underflow_hits, overflow_hits);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("double_ended_queue_core_tb passed");
      end else begin
         $display("double_ended_queue_core_tb failed");
      end
      $finish;
   end

endmodule
